// ----- src/dbpq_pkg.sv -----
// Package for the bucket priority queue: sizes, item codes, payload and
// controller/datapath interface types. No dependencies.
package dbpq_pkg;

  localparam int NODES     = 1024;
  localparam int NODE_W    = $clog2(NODES);
  localparam int BKT_N     = 256;
  localparam int BKT_W     = $clog2(BKT_N);
  localparam int K_W       = BKT_W + 1;
  localparam int COST_W    = 32;
  localparam int TAG_W     = 32;
  localparam int CNT_W     = NODE_W + 1;
  localparam int MW_W      = 8;
  localparam int STEP_W    = $clog2(COST_W);

  // item kinds
  localparam logic [2:0] KIND_PUSH   = 3'd0;
  localparam logic [2:0] KIND_POP    = 3'd1;
  localparam logic [2:0] KIND_PEEK   = 3'd2;
  localparam logic [2:0] KIND_LOOKUP = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  typedef struct packed {
    logic [2:0]        kind;
    logic [NODE_W-1:0] node;
    logic [COST_W-1:0] key_cost;
    logic [TAG_W-1:0]  key_tag;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0] out_node;
    logic [COST_W-1:0] out_cost;
    logic [TAG_W-1:0]  out_tag;
    logic              found;
    logic [CNT_W-1:0]  queue_count;
    logic              queue_empty;
    logic              pop_error;
  } out_t;

  // datapath commands, one per controller step
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CFG,
    CMD_LATCH,
    CMD_SWEEP,
    CMD_DIV,
    CMD_PNEW,
    CMD_U1,
    CMD_U2,
    CMD_A0,
    CMD_A1,
    CMD_SCAN,
    CMD_HEADV,
    CMD_POPFIN,
    CMD_PKCHK,
    CMD_PKFIN,
    CMD_LKFIN,
    CMD_LOAD
  } cmd_e;

  typedef struct packed {
    logic count_zero;
    logic div_busy;
    logic queued;
    logic ne_cur;
    logic sweep_last;
  } stat_t;

endpackage

// ----- src/dbpq_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module dbpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/dbpq_mod.sv -----
// Bit-serial remainder unit: cost modulo bucket count, one bit per cycle.
// Depends on dbpq_pkg.
module dbpq_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dbpq_pkg::COST_W-1:0] dividend_i,
  input  logic [dbpq_pkg::K_W-1:0]    divisor_i,
  output logic                        busy_o,
  output logic [dbpq_pkg::BKT_W-1:0]  rem_o
);
  import dbpq_pkg::*;

  logic              busy_q;
  logic [STEP_W-1:0] cnt_q;
  logic [COST_W-1:0] sh_q;
  logic [BKT_W-1:0]  rem_q;
  logic [K_W-1:0]    trial;
  logic [K_W-1:0]    diff;

  // restoring step
  assign trial = {rem_q, sh_q[COST_W-1]};
  assign diff  = trial - divisor_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == STEP_W'(COST_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= {sh_q[COST_W-2:0], 1'b0};
      rem_q <= (trial >= divisor_i) ? diff[BKT_W-1:0] : trial[BKT_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// ----- src/dbpq_dp.sv -----
// Datapath: link memories, bucket heads/tails, occupancy bits, counters and
// result registers. Depends on dbpq_pkg, dbpq_ram and dbpq_mod.
module dbpq_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dbpq_pkg::cmd_e            cmd_i,
  input  dbpq_pkg::in_t             in_data_i,
  input  logic [dbpq_pkg::MW_W-1:0] cfg_data_i,
  output dbpq_pkg::stat_t           stat_o,
  output dbpq_pkg::out_t            out_data_o
);
  import dbpq_pkg::*;

  logic [NODE_W-1:0] v_q;
  logic [COST_W-1:0] cost_q, rc_q, cur_min_q;
  logic [TAG_W-1:0]  tag_q, rt_q;
  logic              queued_q, hit_q;
  logic [CNT_W-1:0]  count_q;
  logic [BKT_W-1:0]  cur_b_q, ob_q;
  logic [K_W-1:0]    k_q, k_cfg;
  logic [BKT_N-1:0]  ne_q;
  logic [NODE_W-1:0] p_q, n_q, sw_q;
  out_t              res_q, out_q;
  out_t              res_init, res_load;

  logic [BKT_W-1:0]  b;
  logic              div_busy;
  logic [COST_W-1:0] cost_rd;
  logic [TAG_W-1:0]  tag_rd;
  logic [BKT_W-1:0]  bkt_rd;
  logic [NODE_W-1:0] nxt_rd, prv_rd, head_rd, tail_rd;
  logic              qf_rd;
  logic              is_head, is_tail, both, ne_b;
  logic [BKT_W-1:0]  cur_b_inc;
  logic [MW_W-1:0]   w_eff;

  assign is_head = (head_rd == v_q);
  assign is_tail = (tail_rd == v_q);
  assign both    = is_head && is_tail;
  assign ne_b    = ne_q[b];

  // bucket count from the register: zero weight acts as one, capped
  assign w_eff = (cfg_data_i == '0) ? MW_W'(1) : cfg_data_i;
  assign k_cfg = ({1'b0, w_eff} + 1'b1 > K_W'(BKT_N)) ? K_W'(BKT_N)
                                                      : {1'b0, w_eff} + 1'b1;

  assign cur_b_inc = ({1'b0, cur_b_q} + 1'b1 == k_q) ? '0 : cur_b_q + 1'b1;

  // fresh result for a new item, and the result with the counters attached
  always_comb begin
    res_init             = '0;
    res_init.out_cost    = '1;
    res_init.pop_error   = (in_data_i.kind == KIND_POP) && (count_q == '0);
    res_load             = res_q;
    res_load.queue_count = count_q;
    res_load.queue_empty = (count_q == '0);
  end

  dbpq_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i == CMD_LATCH && in_data_i.kind == KIND_PUSH),
    .dividend_i(in_data_i.key_cost),
    .divisor_i (k_q),
    .busy_o    (div_busy),
    .rem_o     (b)
  );

  // per-node stores
  dbpq_ram #(.WIDTH(COST_W), .DEPTH(NODES)) u_cost (
    .clk_i(clk_i), .we_i(cmd_i == CMD_A0), .waddr_i(v_q), .wdata_i(cost_q),
    .raddr_i(v_q), .rdata_o(cost_rd)
  );
  dbpq_ram #(.WIDTH(TAG_W), .DEPTH(NODES)) u_tag (
    .clk_i(clk_i), .we_i(cmd_i == CMD_A0), .waddr_i(v_q), .wdata_i(tag_q),
    .raddr_i(v_q), .rdata_o(tag_rd)
  );
  dbpq_ram #(.WIDTH(BKT_W), .DEPTH(NODES)) u_bkt (
    .clk_i(clk_i), .we_i(cmd_i == CMD_A0), .waddr_i(v_q), .wdata_i(b),
    .raddr_i(v_q), .rdata_o(bkt_rd)
  );
  dbpq_ram #(.WIDTH(1), .DEPTH(NODES)) u_qf (
    .clk_i  (clk_i),
    .we_i   (cmd_i == CMD_SWEEP || cmd_i == CMD_PNEW || cmd_i == CMD_POPFIN),
    .waddr_i((cmd_i == CMD_SWEEP) ? sw_q : v_q),
    .wdata_i(cmd_i == CMD_PNEW),
    .raddr_i(v_q),
    .rdata_o(qf_rd)
  );

  // next, previous, head and tail link writes
  logic              nxt_we, prv_we, head_we, tail_we;
  logic [NODE_W-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd, head_wd, tail_wd;
  logic [BKT_W-1:0]  head_wa, tail_wa, ht_ra, tail_ra;

  always_comb begin
    nxt_we  = 1'b0; nxt_wa  = v_q;  nxt_wd  = v_q;
    prv_we  = 1'b0; prv_wa  = v_q;  prv_wd  = v_q;
    head_we = 1'b0; head_wa = b;    head_wd = v_q;
    tail_we = 1'b0; tail_wa = b;    tail_wd = v_q;
    ht_ra   = cur_b_q;
    tail_ra = cur_b_q;
    case (cmd_i)
      CMD_A0: begin
        nxt_we  = 1'b1;
        tail_ra = b;
      end
      CMD_A1: begin
        if (ne_b) begin
          nxt_we = 1'b1; nxt_wa = tail_rd;
          prv_we = 1'b1; prv_wd = tail_rd;
          tail_we = 1'b1;
        end else begin
          head_we = 1'b1;
          tail_we = 1'b1;
          prv_we  = 1'b1;
        end
      end
      CMD_U1: begin
        ht_ra   = bkt_rd;
        tail_ra = bkt_rd;
      end
      CMD_U2: begin
        if (!both) begin
          if (is_head) begin
            head_we = 1'b1; head_wa = ob_q; head_wd = n_q;
          end else begin
            nxt_we = 1'b1; nxt_wa = p_q; nxt_wd = n_q;
          end
          if (is_tail) begin
            tail_we = 1'b1; tail_wa = ob_q; tail_wd = p_q;
          end else begin
            prv_we = 1'b1; prv_wa = n_q; prv_wd = p_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  dbpq_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_nxt (
    .clk_i(clk_i), .we_i(nxt_we), .waddr_i(nxt_wa), .wdata_i(nxt_wd),
    .raddr_i(v_q), .rdata_o(nxt_rd)
  );
  dbpq_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_prv (
    .clk_i(clk_i), .we_i(prv_we), .waddr_i(prv_wa), .wdata_i(prv_wd),
    .raddr_i(v_q), .rdata_o(prv_rd)
  );
  dbpq_ram #(.WIDTH(NODE_W), .DEPTH(BKT_N)) u_head (
    .clk_i(clk_i), .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd),
    .raddr_i(ht_ra), .rdata_o(head_rd)
  );
  dbpq_ram #(.WIDTH(NODE_W), .DEPTH(BKT_N)) u_tail (
    .clk_i(clk_i), .we_i(tail_we), .waddr_i(tail_wa), .wdata_i(tail_wd),
    .raddr_i(tail_ra), .rdata_o(tail_rd)
  );

  // control state: counters, occupancy, minimum pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      cur_min_q <= '0;
      cur_b_q   <= '0;
      k_q       <= K_W'(2);
      ne_q      <= '0;
      sw_q      <= '0;
    end else begin
      case (cmd_i)
        CMD_CFG: begin
          k_q  <= k_cfg;
          sw_q <= '0;
        end
        CMD_LATCH: sw_q <= '0;
        CMD_SWEEP: begin
          sw_q      <= sw_q + 1'b1;
          count_q   <= '0;
          cur_min_q <= '0;
          cur_b_q   <= '0;
          ne_q      <= '0;
        end
        CMD_PNEW:   count_q <= count_q + 1'b1;
        CMD_POPFIN: count_q <= count_q - 1'b1;
        CMD_SCAN: begin
          if (!ne_q[cur_b_q]) begin
            cur_min_q <= cur_min_q + 1'b1;
            cur_b_q   <= (cur_min_q == '1) ? '0 : cur_b_inc;
          end
        end
        CMD_A1: begin
          if (!ne_b) ne_q[b] <= 1'b1;
        end
        CMD_U2: begin
          if (both) ne_q[ob_q] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // payload and result registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LATCH: begin
        v_q    <= in_data_i.node;
        cost_q <= in_data_i.key_cost;
        tag_q  <= in_data_i.key_tag;
        res_q  <= res_init;
      end
      CMD_DIV:   queued_q <= qf_rd;
      CMD_HEADV: v_q <= head_rd;
      CMD_PKCHK: hit_q <= ne_q[cur_b_q];
      CMD_U1: begin
        ob_q <= bkt_rd;
        p_q  <= prv_rd;
        n_q  <= nxt_rd;
        rc_q <= cost_rd;
        rt_q <= tag_rd;
      end
      CMD_POPFIN: begin
        res_q.out_node <= v_q;
        res_q.out_cost <= rc_q;
        res_q.out_tag  <= rt_q;
        res_q.found    <= 1'b1;
      end
      CMD_PKFIN: begin
        if (hit_q) begin
          res_q.out_node <= v_q;
          res_q.out_cost <= cost_rd;
          res_q.out_tag  <= tag_rd;
          res_q.found    <= 1'b1;
        end
      end
      CMD_LKFIN: begin
        if (qf_rd) begin
          res_q.out_node <= v_q;
          res_q.out_cost <= cost_rd;
          res_q.out_tag  <= tag_rd;
          res_q.found    <= 1'b1;
        end
      end
      CMD_LOAD: out_q <= res_load;
      default: begin
      end
    endcase
  end

  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.div_busy   = div_busy;
  assign stat_o.queued     = queued_q;
  assign stat_o.ne_cur     = ne_q[cur_b_q];
  assign stat_o.sweep_last = (sw_q == NODE_W'(NODES - 1));
  assign out_data_o        = out_q;

endmodule

// ----- src/dbpq_ctrl.sv -----
// Controller state machine: sequences each item into datapath commands and
// runs the handshakes. Depends on dbpq_pkg.
module dbpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        in_kind_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  dbpq_pkg::stat_t   stat_i,
  output dbpq_pkg::cmd_e    cmd_o
);
  import dbpq_pkg::*;

  typedef enum logic [4:0] {
    S_SWEEP, S_IDLE, S_CLR, S_PDIV, S_PNEW, S_U0, S_U1, S_U2, S_A0, S_A1,
    S_SCAN, S_PH, S_POPFIN, S_PK0, S_PK1, S_PK2, S_PK3, S_LK0, S_LK1, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, push_q;
  logic   load;

  assign load        = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign out_valid_o = out_valid_q;

  // command and next state
  always_comb begin
    cmd_o   = CMD_NONE;
    state_d = state_q;
    case (state_q)
      S_SWEEP: begin
        cmd_o = CMD_SWEEP;
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_CLR: begin
        cmd_o = CMD_SWEEP;
        if (stat_i.sweep_last) state_d = S_DONE;
      end
      S_IDLE: begin
        if (cfg_valid_i) begin
          cmd_o   = CMD_CFG;
          state_d = S_SWEEP;
        end else if (in_valid_i) begin
          cmd_o = CMD_LATCH;
          case (in_kind_i)
            KIND_PUSH:   state_d = S_PDIV;
            KIND_POP:    state_d = stat_i.count_zero ? S_DONE : S_SCAN;
            KIND_PEEK:   state_d = S_PK0;
            KIND_LOOKUP: state_d = S_LK0;
            KIND_CLEAR:  state_d = S_CLR;
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_PDIV: begin
        cmd_o = CMD_DIV;
        if (!stat_i.div_busy) state_d = stat_i.queued ? S_U0 : S_PNEW;
      end
      S_PNEW: begin
        cmd_o   = CMD_PNEW;
        state_d = S_A0;
      end
      S_U0: state_d = S_U1;
      S_U1: begin
        cmd_o   = CMD_U1;
        state_d = S_U2;
      end
      S_U2: begin
        cmd_o   = CMD_U2;
        state_d = push_q ? S_A0 : S_POPFIN;
      end
      S_A0: begin
        cmd_o   = CMD_A0;
        state_d = S_A1;
      end
      S_A1: begin
        cmd_o   = CMD_A1;
        state_d = S_DONE;
      end
      S_SCAN: begin
        cmd_o = CMD_SCAN;
        if (stat_i.ne_cur) state_d = S_PH;
      end
      S_PH: begin
        cmd_o   = CMD_HEADV;
        state_d = S_U0;
      end
      S_POPFIN: begin
        cmd_o   = CMD_POPFIN;
        state_d = S_DONE;
      end
      S_PK0: begin
        cmd_o   = CMD_PKCHK;
        state_d = S_PK1;
      end
      S_PK1: begin
        cmd_o   = CMD_HEADV;
        state_d = S_PK2;
      end
      S_PK2: state_d = S_PK3;
      S_PK3: begin
        cmd_o   = CMD_PKFIN;
        state_d = S_DONE;
      end
      S_LK0: state_d = S_LK1;
      S_LK1: begin
        cmd_o   = CMD_LKFIN;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (load) begin
          cmd_o   = CMD_LOAD;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      out_valid_q <= 1'b0;
      push_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && in_valid_i && !cfg_valid_i) begin
        push_q <= (in_kind_i == KIND_PUSH);
      end
      if (state_q == S_DONE && load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> !stat_i.count_zero)
    else $error("scan with empty queue");

  a_popfin_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o == CMD_POPFIN |-> !stat_i.count_zero)
    else $error("pop removes from empty queue");

  a_append_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_A0 |-> !stat_i.div_busy)
    else $error("append before bucket index is ready");

  a_cfg_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> state_q == S_SWEEP)
    else $error("config write did not start clearing");
`endif

endmodule

// ----- src/dial_bucket_priority_queue_unit.sv -----
// Top level of the bucket priority queue: controller plus datapath.
// Depends on dbpq_pkg, dbpq_ctrl and dbpq_dp.
//
// Usage:
//  - Input channel (in_valid_i/in_stall_o/in_data_i) carries push, pop, peek,
//    lookup and clear items; a transfer happens when valid is high and
//    stall is low. Every item gives exactly one result transfer on the
//    output channel (out_valid_o/out_stall_i/out_data_o).
//  - Configuration channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the
//    largest edge weight; it also empties the queue.
//  - One item is in work at a time. A push waits on the bit-serial remainder
//    unit and, when it decreases a queued node, first unlinks that node; a
//    pop steps over each empty bucket before the first occupied one, and a
//    pop on an empty queue skips the scan.
//  - Clear and every configuration write sweep the 1024-entry queued-flag
//    memory, one entry per cycle, with input stalled.
//  - After reset the same sweep runs before the first item.
//  - The result sits in an output register; while the receiver stalls the
//    block finishes the next item and holds it until the register drains.
module dial_bucket_priority_queue_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  dbpq_pkg::in_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output dbpq_pkg::out_t            out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [dbpq_pkg::MW_W-1:0] cfg_data_i
);
  import dbpq_pkg::*;

  cmd_e  cmd;
  stat_t stat;

  dbpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_kind_i  (in_data_i.kind),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dbpq_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (in_data_i),
    .cfg_data_i(cfg_data_i),
    .stat_o    (stat),
    .out_data_o(out_data_o)
  );

endmodule

// ----- tb/dbpq_checker.sv -----
// Scoreboard for the bucket priority queue: watches the item, result and
// configuration channels, predicts every result and compares. Needs dbpq_pkg.
module dbpq_checker
  import dbpq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  in_t              in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  out_t             out_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [MW_W-1:0]  cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RES_DEPTH = 16;

  // shadow copy of the queue
  logic              queued_q  [NODES];
  logic [COST_W-1:0] cost_q    [NODES];
  logic [TAG_W-1:0]  tag_q     [NODES];
  logic [BKT_W-1:0]  home_q    [NODES];
  logic [NODE_W-1:0] fwd_q     [NODES];
  logic [NODE_W-1:0] back_q    [NODES];
  logic [NODE_W-1:0] head_q    [BKT_N];
  logic [NODE_W-1:0] tail_q    [BKT_N];
  logic              busy_bkt_q[BKT_N];
  logic [COST_W-1:0] min_cost_q;
  int                depth_q;
  logic [MW_W-1:0]   weight_q;

  // expected results in order, as a small ring
  out_t       result_mem[RES_DEPTH];
  logic [3:0] res_rd_q, res_wr_q;
  int         res_fill_q;

  function automatic int unsigned bucket_total();
    int unsigned k;
    k = (weight_q == 0) ? 2 : int'(weight_q) + 1;
    return (k > BKT_N) ? BKT_N : k;
  endfunction

  task automatic empty_queue();
    for (int i = 0; i < NODES; i++) queued_q[i] = 1'b0;
    for (int i = 0; i < BKT_N; i++) busy_bkt_q[i] = 1'b0;
    min_cost_q = '0;
    depth_q    = 0;
  endtask

  // remove a node from its bucket list
  task automatic unlink(input logic [NODE_W-1:0] v);
    logic [BKT_W-1:0]  b;
    logic [NODE_W-1:0] p, n;
    logic              at_head, at_tail;
    b = home_q[v];
    p = back_q[v];
    n = fwd_q[v];
    at_head = (head_q[b] == v);
    at_tail = (tail_q[b] == v);
    if (at_head && at_tail) begin
      busy_bkt_q[b] = 1'b0;
    end else begin
      if (at_head) head_q[b] = n; else fwd_q[p] = n;
      if (at_tail) tail_q[b] = p; else back_q[n] = p;
    end
  endtask

  // append a node at the tail of a bucket
  task automatic link_tail(input logic [NODE_W-1:0] v, input logic [BKT_W-1:0] b);
    if (busy_bkt_q[b]) begin
      fwd_q[tail_q[b]] = v;
      back_q[v] = tail_q[b];
      tail_q[b] = v;
    end else begin
      head_q[b] = v;
      tail_q[b] = v;
      back_q[v] = v;
      busy_bkt_q[b] = 1'b1;
    end
    fwd_q[v]  = v;
    home_q[v] = b;
  endtask

  task automatic report_node(inout out_t r, input logic [NODE_W-1:0] v);
    r.out_node = v;
    r.out_cost = cost_q[v];
    r.out_tag  = tag_q[v];
    r.found    = 1'b1;
  endtask

  // next queue state and the result of one item
  task automatic apply_item(input in_t it, output out_t r);
    int unsigned       k;
    int unsigned       steps;
    logic [BKT_W-1:0]  b;
    logic [NODE_W-1:0] v;
    k = bucket_total();
    r = '0;
    r.out_cost = '1;
    case (it.kind)
      KIND_PUSH: begin
        b = BKT_W'(it.key_cost % k);
        if (queued_q[it.node]) begin
          unlink(it.node);
        end else begin
          queued_q[it.node] = 1'b1;
          depth_q++;
        end
        cost_q[it.node] = it.key_cost;
        tag_q[it.node]  = it.key_tag;
        link_tail(it.node, b);
      end
      KIND_POP: begin
        if (depth_q == 0) begin
          r.pop_error = 1'b1;
        end else begin
          // walk forward to the first occupied bucket
          b = BKT_W'(min_cost_q % k);
          steps = 0;
          while (!busy_bkt_q[b] && steps < 2 * k) begin
            min_cost_q = min_cost_q + 1;
            b = BKT_W'(min_cost_q % k);
            steps++;
          end
          if (busy_bkt_q[b]) begin
            v = head_q[b];
            unlink(v);
            queued_q[v] = 1'b0;
            depth_q--;
            report_node(r, v);
          end else begin
            r.pop_error = 1'b1;
          end
        end
      end
      KIND_PEEK: begin
        b = BKT_W'(min_cost_q % k);
        if (busy_bkt_q[b]) report_node(r, head_q[b]);
      end
      KIND_LOOKUP: begin
        if (queued_q[it.node]) report_node(r, it.node);
      end
      KIND_CLEAR: empty_queue();
      default: ;
    endcase
    r.queue_count = CNT_W'(depth_q);
    r.queue_empty = (depth_q == 0);
  endtask

  // observe transfers at each edge: results first, then configuration, then new items
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        cost_q[i] = '1;
        tag_q[i]  = '0;
      end
      weight_q = MW_W'(1);
      empty_queue();
      res_rd_q     = '0;
      res_wr_q     = '0;
      res_fill_q   = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (res_fill_q == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual %p",
                   $realtime, got);
          fail_count_o++;
        end else begin
          want = result_mem[res_rd_q];
          res_rd_q++;
          res_fill_q--;
          if (got !== want) begin
            $display("%0t: result mismatch, expected %p, actual %p",
                     $realtime, want, got);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        weight_q = cfg_data_i;
        empty_queue();
      end
      if (in_valid_i && !in_stall_i) begin
        apply_item(in_data_i, want);
        if (res_fill_q == RES_DEPTH) begin
          $display("%0t: results overdue, expected at most %0d pending, actual %0d",
                   $realtime, RES_DEPTH, res_fill_q + 1);
          fail_count_o++;
        end else begin
          result_mem[res_wr_q] = want;
          res_wr_q++;
          res_fill_q++;
        end
      end
      pending_o = res_fill_q;
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the bucket priority queue regression: clock, reset, item and
// configuration stimulus, receiver stalls and verdict. Needs dbpq_pkg,
// dbpq_checker and dial_bucket_priority_queue_unit.
module testbench;
  import dbpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  in_t             in_data_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_t            out_data_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [MW_W-1:0] cfg_data_i = '0;
  int              fail_count;
  int              pending;

  logic              quiet = 1'b0;     // no idling on either side
  logic              long_hold = 1'b0; // request one long receiver hold-off
  logic [MW_W-1:0]   weight = MW_W'(1);
  logic [COST_W-1:0] cost_base = '0;   // recent cost seen at the output

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  dial_bucket_priority_queue_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  dbpq_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_i(in_stall_o), .in_data_i(in_data_i),
    .out_valid_i(out_valid_o), .out_stall_i(out_stall_i), .out_data_i(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_i(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // follow the output costs so pushes land near the current minimum
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i && out_data_o.found) cost_base <= out_data_o.out_cost;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
        long_hold = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 29) == 0) begin
        // a stretch with no stalls
        out_stall_i <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // offer one item and hold it until the transfer
  task automatic send(input logic [2:0] kind, input logic [NODE_W-1:0] node,
                      input logic [COST_W-1:0] cost, input logic [TAG_W-1:0] tag);
    in_t it;
    it.kind = kind;
    it.node = node;
    it.key_cost = cost;
    it.key_tag = tag;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop offering, wait for every result, then write the weight register
  task automatic drain_and_configure(input logic [MW_W-1:0] w);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    weight = w;
  endtask

  // mostly well-formed traffic on a small node pool, some noise
  task automatic random_items(input int count);
    int unsigned       pick;
    int unsigned       span;
    logic [NODE_W-1:0] node;
    logic [COST_W-1:0] cost;
    for (int i = 0; i < count; i++) begin
      span = (weight == 0) ? 1 : weight;
      pick = $urandom_range(0, 99);
      node = ($urandom_range(0, 3) != 0) ? NODE_W'($urandom_range(0, 15))
                                         : NODE_W'($urandom_range(0, NODES - 1));
      cost = cost_base + $urandom_range(0, span);
      if ($urandom_range(0, 19) == 0) cost = $urandom_range(0, 32'hFFFF_FFFE);
      if (cost == '1) cost = 32'hFFFF_FFFE;
      if (pick < 45)      send(KIND_PUSH, node, cost, $urandom());
      else if (pick < 78) send(KIND_POP, node, cost, $urandom());
      else if (pick < 86) send(KIND_PEEK, node, cost, $urandom());
      else if (pick < 97) send(KIND_LOOKUP, node, cost, $urandom());
      else if (pick < 98) send(KIND_CLEAR, node, cost, $urandom());
      else                send(3'($urandom_range(5, 7)), node, cost, $urandom());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero weight acts as one
    drain_and_configure(MW_W'(0));
    send(KIND_POP, '0, '0, '0);
    send(KIND_PEEK, '0, '0, '0);
    send(KIND_PUSH, '0, '0, '0);
    send(KIND_PUSH, '1, 32'hFFFF_FFFE, '1);
    send(KIND_PUSH, NODE_W'(5), 32'd3, 32'hA5A5_5A5A);
    send(KIND_PUSH, NODE_W'(5), 32'd2, 32'h1234_5678);  // decrease
    send(KIND_LOOKUP, NODE_W'(5), '0, '0);
    send(KIND_LOOKUP, NODE_W'(7), '0, '0);
    send(KIND_PEEK, '0, '0, '0);
    send(KIND_POP, '0, '0, '0);
    send(KIND_POP, '0, '0, '0);
    send(KIND_POP, '0, '0, '0);
    send(KIND_POP, '0, '0, '0);
    send(3'd5, '1, '1, '1);
    send(3'd7, '0, '0, '0);
    send(KIND_PUSH, NODE_W'(9), 32'd7, 32'd1);
    send(KIND_CLEAR, '0, '0, '0);
    send(KIND_LOOKUP, NODE_W'(9), '0, '0);
    send(KIND_POP, '0, '0, '0);

    // directed: widest bucket ring, long scans
    drain_and_configure(MW_W'(255));
    send(KIND_PUSH, NODE_W'(3), 32'd255, 32'hDEAD_BEEF);
    send(KIND_PUSH, NODE_W'(4), 32'd256, 32'h0);
    send(KIND_POP, '0, '0, '0);
    send(KIND_PEEK, '0, '0, '0);
    send(KIND_POP, '0, '0, '0);

    // random phases over several weights, one with a long hold-off
    long_hold = 1'b1;
    random_items(300);
    drain_and_configure(MW_W'(1));
    random_items(250);
    drain_and_configure(MW_W'($urandom_range(2, 254)));
    random_items(250);
    drain_and_configure(MW_W'($urandom_range(1, 16)));
    random_items(250);
    drain_and_configure(MW_W'(255));
    random_items(100);
    quiet = 1'b1;
    random_items(200);

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // guard against a hang
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
src/dbpq_pkg.sv
src/dbpq_ram.sv
src/dbpq_mod.sv
src/dbpq_dp.sv
src/dbpq_ctrl.sv
src/dial_bucket_priority_queue_unit.sv
tb/dbpq_checker.sv
tb/testbench.sv
